// ===== hdl/disk_sector_offset_calc_assert.svh =====
// Assertion macros shared by the sector offset calculator RTL.
`ifndef DISK_SECTOR_OFFSET_CALC_ASSERT_SVH
`define DISK_SECTOR_OFFSET_CALC_ASSERT_SVH

// Implication checked while out of reset.
`define DSOC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define DSOC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dsoc_pkg.sv =====
// Types, codes and zone tables for the sector offset calculator.
package dsoc_pkg;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_ADDR    = 3'd1;
    localparam logic [2:0] ST_SHORT       = 3'd2;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
    localparam logic [2:0] ST_READ_ONLY   = 3'd4;

    localparam logic [1:0] MODE_ZONED  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;

    localparam logic [2:0] CFG_LAYOUT_MODE    = 3'd0;
    localparam logic [2:0] CFG_HEAD_COUNT     = 3'd1;
    localparam logic [2:0] CFG_TRACK_SECTORS  = 3'd2;
    localparam logic [2:0] CFG_SECTOR_BYTES   = 3'd3;
    localparam logic [2:0] CFG_IMAGE_WRITABLE = 3'd4;

    localparam logic [7:0]  ZONE_TRACKS       = 8'd35;
    localparam logic [10:0] ZONE_SECTOR_BYTES = 11'd256;

    // Sectors per zoned track.
    localparam logic [4:0] ZONE_SECTORS [0:34] = '{
        5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
        5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
        5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
        5'd17, 5'd17, 5'd17, 5'd17, 5'd17
    };

    // Sectors in all tracks ahead of each zoned track.
    localparam logic [9:0] ZONE_BASE [0:34] = '{
        10'd0,   10'd21,  10'd42,  10'd63,  10'd84,  10'd105, 10'd126,
        10'd147, 10'd168, 10'd189, 10'd210, 10'd231, 10'd252, 10'd273,
        10'd294, 10'd315, 10'd336,
        10'd357, 10'd376, 10'd395, 10'd414, 10'd433, 10'd452, 10'd471,
        10'd490, 10'd508, 10'd526, 10'd544, 10'd562, 10'd580,
        10'd598, 10'd615, 10'd632, 10'd649, 10'd666
    };

    typedef struct packed {
        logic [1:0]  layout_mode;
        logic [4:0]  head_count;
        logic [5:0]  track_sectors;
        logic [10:0] sector_bytes;
        logic        image_writable;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [7:0]  track_index;
        logic [3:0]  head_index;
        logic [7:0]  sector_index;
        logic [15:0] buffer_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [27:0] byte_offset;
        logic [10:0] transfer_bytes;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  status;
        logic        linear;
        logic [12:0] track_heads;
        logic [3:0]  head;
        logic [7:0]  sector;
        logic [9:0]  zone_block;
    } t_s1;

    typedef struct packed {
        logic [2:0]  status;
        logic        linear;
        logic [18:0] lin_block;
        logic [9:0]  zone_block;
    } t_s2;

    typedef struct packed {
        logic [2:0]  status;
        logic        linear;
        logic [29:0] lin_offset;
        logic [9:0]  zone_block;
    } t_s3;

endpackage

// ===== hdl/dsoc_decode.sv =====
// First stage: request checks, zone lookup and track times heads.
module dsoc_decode
    import dsoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_req i_req,
    input  logic i_ready,
    output logic o_ready,
    output logic o_valid,
    output t_s1  o_s1
);

    logic        r_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [10:0] ssize;
    logic [5:0]  zidx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    always_comb begin
        ssize = (i_cfg.layout_mode == MODE_ZONED) ? ZONE_SECTOR_BYTES : i_cfg.sector_bytes;
        zidx  = (i_req.track_index < ZONE_TRACKS) ? i_req.track_index[5:0] : 6'd0;

        n_s1.linear      = (i_cfg.layout_mode == MODE_LINEAR);
        n_s1.track_heads = 13'(i_req.track_index) * 13'(i_cfg.head_count);
        n_s1.head        = i_req.head_index;
        n_s1.sector      = i_req.sector_index;
        n_s1.zone_block  = ZONE_BASE[zidx] + 10'(i_req.sector_index);

        // Priority: write protect, short buffer, layout, address range.
        if (i_req.action && !i_cfg.image_writable) begin
            n_s1.status = ST_READ_ONLY;
        end else if (i_req.buffer_bytes < 16'(ssize)) begin
            n_s1.status = ST_SHORT;
        end else if (i_cfg.layout_mode == MODE_ZONED) begin
            if (i_req.action) begin
                n_s1.status = ST_UNSUPPORTED;
            end else if (i_req.track_index >= ZONE_TRACKS ||
                         i_req.sector_index >= 8'(ZONE_SECTORS[zidx])) begin
                n_s1.status = ST_BAD_ADDR;
            end else begin
                n_s1.status = ST_OK;
            end
        end else if (i_cfg.layout_mode == MODE_LINEAR) begin
            n_s1.status = (i_req.sector_index >= 8'(i_cfg.track_sectors)) ?
                          ST_BAD_ADDR : ST_OK;
        end else begin
            n_s1.status = ST_UNSUPPORTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

// ===== hdl/dsoc_scale.sv =====
// Second and third stages: linear sector number, then scale by sector size.
module dsoc_scale
    import dsoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_valid,
    input  t_s1  i_s1,
    input  logic i_ready,
    output logic o_ready,
    output logic o_valid,
    output t_s3  o_s3
);

    logic r_v2;
    logic r_v3;
    t_s2  r_s2;
    t_s3  r_s3;
    t_s2  n_s2;
    t_s3  n_s3;
    logic ready3;

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = !r_v2 || ready3;
    assign o_valid = r_v3;
    assign o_s3    = r_s3;

    always_comb begin
        n_s2.status     = i_s1.status;
        n_s2.linear     = i_s1.linear;
        n_s2.zone_block = i_s1.zone_block;
        n_s2.lin_block  = 19'(i_s1.track_heads + 13'(i_s1.head)) *
                          19'(i_cfg.track_sectors) + 19'(i_s1.sector);

        n_s3.status     = r_s2.status;
        n_s3.linear     = r_s2.linear;
        n_s3.zone_block = r_s2.zone_block;
        n_s3.lin_offset = 30'(r_s2.lin_block) * 30'(i_cfg.sector_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
        if (ready3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

endmodule

// ===== hdl/disk_sector_offset_calc.sv =====
// Top level of the disk sector offset calculator.
// Maps one sector request (read or write, track, head, sector, buffer length)
// to a byte offset in the disk image and a transfer length, or to an error
// status. The path is four register stages deep: checks and zone lookup,
// track*heads+head times sectors per track plus sector, scale by sector size,
// then the overflow check into the output register. While o_stall is low a
// request enters every cycle, so throughput is one request per clock; each
// request passes stages 2 and 3 into the output register, where o_valid rises.
// Each stage holds its request only while the stage ahead is full and stalled;
// o_stall rises only when all four stages are occupied. Configuration registers
// are read live by every stage, so write them only while no request is in flight.
`include "disk_sector_offset_calc_assert.svh"

module disk_sector_offset_calc
    import dsoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    // response channel
    output logic        o_valid,
    input  logic        i_stall,
    output t_rsp        o_rsp
);

    // Configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode    <= 2'd2;
            r_cfg.head_count     <= 5'd2;
            r_cfg.track_sectors  <= 6'd18;
            r_cfg.sector_bytes   <= 11'd512;
            r_cfg.image_writable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYOUT_MODE:    r_cfg.layout_mode    <= i_cfg_data[1:0];
                CFG_HEAD_COUNT:     r_cfg.head_count     <= i_cfg_data[4:0];
                CFG_TRACK_SECTORS:  r_cfg.track_sectors  <= i_cfg_data[5:0];
                CFG_SECTOR_BYTES:   r_cfg.sector_bytes   <= i_cfg_data;
                CFG_IMAGE_WRITABLE: r_cfg.image_writable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage 1: checks
    logic dec_ready;
    logic dec_valid;
    t_s1  dec_s1;
    logic scl_ready;
    logic scl_valid;
    t_s3  scl_s3;

    // Stage 4: output register
    logic r_o_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;
    logic out_ready;

    assign out_ready = !r_o_valid || !i_stall;
    assign o_stall   = !dec_ready;
    assign o_valid   = r_o_valid;
    assign o_rsp     = r_rsp;

    dsoc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_req   (i_req),
        .i_ready (scl_ready),
        .o_ready (dec_ready),
        .o_valid (dec_valid),
        .o_s1    (dec_s1)
    );

    // Stages 2 and 3: linear address arithmetic
    dsoc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (dec_valid),
        .i_s1    (dec_s1),
        .i_ready (out_ready),
        .o_ready (scl_ready),
        .o_valid (scl_valid),
        .o_s3    (scl_s3)
    );

    // Final status: a linear offset at or past 2^28 is a bad address.
    always_comb begin
        n_rsp.status         = scl_s3.status;
        n_rsp.byte_offset    = 28'd0;
        n_rsp.transfer_bytes = 11'd0;
        if (scl_s3.status == ST_OK) begin
            if (scl_s3.linear) begin
                if (scl_s3.lin_offset[29:28] != 2'd0) begin
                    n_rsp.status = ST_BAD_ADDR;
                end else begin
                    n_rsp.byte_offset    = scl_s3.lin_offset[27:0];
                    n_rsp.transfer_bytes = r_cfg.sector_bytes;
                end
            end else begin
                n_rsp.byte_offset    = {10'd0, scl_s3.zone_block, 8'd0};
                n_rsp.transfer_bytes = ZONE_SECTOR_BYTES;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= scl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && scl_valid) begin
            r_rsp <= n_rsp;
        end
    end

    // Errors never carry an offset or a length.
    `DSOC_ASSERT_IMP(a_err_zero, o_valid && o_rsp.status != ST_OK, o_rsp.byte_offset == 28'd0 && o_rsp.transfer_bytes == 11'd0, "error response carries offset or length")
    // Back-pressure reaches the input only when every stage is full.
    `DSOC_ASSERT_IMP(a_stall_full, o_stall, dec_valid && scl_valid && r_o_valid && i_stall, "input stalled with a free stage")
    // A good response moves one zoned sector or one configured sector.
    `DSOC_ASSERT_IMP(a_ok_len, o_valid && o_rsp.status == ST_OK, o_rsp.transfer_bytes == ZONE_SECTOR_BYTES || o_rsp.transfer_bytes == r_cfg.sector_bytes, "bad transfer length")
    // Reset empties the pipeline.
    `DSOC_ASSERT_NEXT(a_rst_empty, !i_rst_n, !o_valid && !dec_valid && !scl_valid, "pipeline not empty after reset")

endmodule
